>>> rtl/pixel_to_hex_cube_round_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for pixel_to_hex_cube_round
// Shared property wrappers used by the checker file p2h_checker.
// ----------------------------------------------------------------------------
`ifndef PIXEL_TO_HEX_CUBE_ROUND_DEFINES_SVH
`define PIXEL_TO_HEX_CUBE_ROUND_DEFINES_SVH

// property checked only outside reset
`define P2H_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define P2H_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/p2h_pkg.sv
// ----------------------------------------------------------------------------
// p2h_pkg
// Types, widths, register codes and arithmetic helpers for the pixel to
// hex cube rounding pipeline.
// ----------------------------------------------------------------------------
package p2h_pkg;

   localparam int FRAC_BITS  = 16;

   localparam int PIX_W      = 16;
   localparam int COEF_W     = 18;
   localparam int CELL_W     = 10;
   localparam int CUBE_W     = 14;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // offset from origin and its magnitude
   localparam int OFF_W      = PIX_W + 1;
   localparam int MAG_W      = PIX_W;

   // pipelined divider: quotient bits resolved per stage
   localparam int DIV_W      = MAG_W + FRAC_BITS;
   localparam int DIV_BPS    = 4;
   localparam int DIV_STG    = (DIV_W + DIV_BPS - 1) / DIV_BPS;
   localparam int DIV_PAD_W  = DIV_STG * DIV_BPS;
   // magnitude stage, division stages, sign stage
   localparam int DIV_LAT    = DIV_STG + 2;

   localparam int REL_W      = DIV_PAD_W + 1;
   localparam int PROD_W     = COEF_W + REL_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int FIX_W      = SUM_W - FRAC_BITS;
   localparam int FZ_W       = FIX_W + 1;
   localparam int INT_W      = FZ_W - FRAC_BITS + 1;
   localparam int ALT_W      = INT_W + 1;
   localparam int ERR_W      = FRAC_BITS;

   // multiply, sum, round xy, round z, select, output
   localparam int LAT        = DIV_LAT + 6;

   typedef logic signed [PIX_W-1:0]      pixel_type;
   typedef logic signed [COEF_W-1:0]     coef_type;
   typedef logic        [CELL_W-1:0]     cell_type;
   typedef logic signed [CUBE_W-1:0]     cube_type;
   typedef logic        [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic        [CSR_DATA_W-1:0] csr_data_type;
   typedef logic signed [OFF_W-1:0]      off_type;
   typedef logic signed [REL_W-1:0]      rel_type;
   typedef logic signed [PROD_W-1:0]     prod_type;
   typedef logic signed [SUM_W-1:0]      sum_type;
   typedef logic signed [FIX_W-1:0]      fix_type;
   typedef logic signed [FZ_W-1:0]       fz_type;
   typedef logic signed [INT_W-1:0]      int_type;
   typedef logic signed [ALT_W-1:0]      alt_type;
   typedef logic        [ERR_W-1:0]      err_type;

   typedef struct packed {
      logic [CELL_W-1:0]    rem;
      logic [DIV_PAD_W-1:0] word;
   } div_state_type;

   localparam csr_idx_type CSR_COEF_B0   = CSR_IDX_W'(0);
   localparam csr_idx_type CSR_COEF_B1   = CSR_IDX_W'(1);
   localparam csr_idx_type CSR_COEF_B2   = CSR_IDX_W'(2);
   localparam csr_idx_type CSR_COEF_B3   = CSR_IDX_W'(3);
   localparam csr_idx_type CSR_ORIGIN_X  = CSR_IDX_W'(4);
   localparam csr_idx_type CSR_ORIGIN_Y  = CSR_IDX_W'(5);
   localparam csr_idx_type CSR_CELL_SIZE = CSR_IDX_W'(6);

   localparam coef_type  COEF_B0_RST   = COEF_W'(37837);
   localparam coef_type  COEF_B1_RST   = COEF_W'(-21845);
   localparam coef_type  COEF_B2_RST   = COEF_W'(0);
   localparam coef_type  COEF_B3_RST   = COEF_W'(43691);
   localparam pixel_type ORIGIN_RST    = PIX_W'(0);
   localparam cell_type  CELL_SIZE_RST = CELL_W'(10);

   localparam cube_type CUBE_MIN = {1'b1, {(CUBE_W-1){1'b0}}};
   localparam cube_type CUBE_MAX = {1'b0, {(CUBE_W-1){1'b1}}};

   localparam logic [FRAC_BITS-1:0] FRAC_HALF = FRAC_BITS'(1) << (FRAC_BITS - 1);

   // nearest integer, ties away from zero
   function automatic int_type round_int(fz_type v);
      fz_type fl;
      logic   up;
      fl = v >>> FRAC_BITS;
      if (v[FZ_W-1]) begin
         up = (v[FRAC_BITS-1:0] > FRAC_HALF);
      end else begin
         up = (v[FRAC_BITS-1:0] >= FRAC_HALF);
      end
      return INT_W'(fl) + int_type'(up);
   endfunction

   // distance to the nearest integer, same for either sign
   function automatic err_type round_err(logic [FRAC_BITS-1:0] f);
      logic [FRAC_BITS-1:0] nf;
      nf = ~f + FRAC_BITS'(1);
      return (f < FRAC_HALF) ? f : nf;
   endfunction

   function automatic cube_type sat_cube(alt_type v);
      cube_type r;
      if (v < CUBE_MIN) begin
         r = CUBE_MIN;
      end else if (v > CUBE_MAX) begin
         r = CUBE_MAX;
      end else begin
         r = CUBE_W'(v);
      end
      return r;
   endfunction

endpackage

>>> rtl/p2h_req_if.sv
// ----------------------------------------------------------------------------
// p2h_req_if
// Pixel request channel: valid/ready with the screen point.
// ----------------------------------------------------------------------------
interface p2h_req_if;
   logic                valid;
   logic                ready;
   p2h_pkg::pixel_type  pixel_x;
   p2h_pkg::pixel_type  pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

>>> rtl/p2h_rsp_if.sv
// ----------------------------------------------------------------------------
// p2h_rsp_if
// Cube coordinate response channel: valid/ready with q, r and s.
// ----------------------------------------------------------------------------
interface p2h_rsp_if;
   logic               valid;
   logic               ready;
   p2h_pkg::cube_type  cube_q;
   p2h_pkg::cube_type  cube_r;
   p2h_pkg::cube_type  cube_s;

   modport source (output valid, output cube_q, output cube_r, output cube_s,
                   input ready);
   modport sink   (input valid, input cube_q, input cube_r, input cube_s,
                   output ready);
endinterface

>>> rtl/p2h_div.sv
// ----------------------------------------------------------------------------
// p2h_div
// Pipelined signed divide of (offset << FRAC_BITS) by the cell size,
// truncating toward zero, a few quotient bits per stage.
// ----------------------------------------------------------------------------
module p2h_div (
   input  logic               clock,
   input  logic               advance,
   input  p2h_pkg::cell_type  divisor,
   input  p2h_pkg::off_type   offset,
   output p2h_pkg::rel_type   rel
);
   import p2h_pkg::*;

   logic [MAG_W-1:0]   mag_ff;
   logic               neg_ff;
   logic [DIV_STG-1:0] sgn_ff;
   div_state_type      st_ff [DIV_STG];
   div_state_type      st_in [DIV_STG];
   div_state_type      start;
   rel_type            rel_ff;
   rel_type            rel_in;
   logic [MAG_W-1:0]   mag_in;

   // restoring division, remainder always stays below the divisor
   function automatic div_state_type div_steps(div_state_type s, cell_type d);
      logic [CELL_W:0] t;
      div_state_type   r;
      r = s;
      for (int i = 0; i < DIV_BPS; i++) begin
         t = {r.rem, r.word[DIV_PAD_W-1]};
         if (t >= {1'b0, d}) begin
            r.rem  = CELL_W'(t - {1'b0, d});
            r.word = {r.word[DIV_PAD_W-2:0], 1'b1};
         end else begin
            r.rem  = CELL_W'(t);
            r.word = {r.word[DIV_PAD_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   assign mag_in = offset[OFF_W-1] ? MAG_W'(-offset) : MAG_W'(offset);

   always_comb begin
      start.rem  = '0;
      start.word = DIV_PAD_W'({mag_ff, {FRAC_BITS{1'b0}}});
      st_in[0]   = div_steps(start, divisor);
      for (int k = 1; k < DIV_STG; k++) begin
         st_in[k] = div_steps(st_ff[k-1], divisor);
      end
   end

   assign rel_in = sgn_ff[DIV_STG-1] ? -$signed({1'b0, st_ff[DIV_STG-1].word})
                                     :  $signed({1'b0, st_ff[DIV_STG-1].word});

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff <= mag_in;
         neg_ff <= offset[OFF_W-1];
         sgn_ff <= {sgn_ff[DIV_STG-2:0], neg_ff};
         for (int k = 0; k < DIV_STG; k++) begin
            st_ff[k] <= st_in[k];
         end
         rel_ff <= rel_in;
      end
   end

   assign rel = rel_ff;

endmodule

>>> rtl/pixel_to_hex_cube_round.sv
// ----------------------------------------------------------------------------
// pixel_to_hex_cube_round
// Maps a screen pixel to the hexagon cell holding it, in cube coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one screen point (pixel_x, pixel_y); rsp returns the cell
//   as saturated cube coordinates (cube_q, cube_r, cube_s), one result per
//   point, in order. Both are valid/ready channels.
//   csr_we/csr_index/csr_wdata write the matrix, origin and cell size;
//   write them only while no point is in flight. Out of range indexes are
//   ignored, a cell size of zero divides by one.
//   A point passes the pipelined divider (4 quotient bits per stage at
//   16 fraction bits), then multiply, sum, two rounding steps, select and
//   saturate into the output register that drives rsp.
//   Throughput is one point per clock; req.ready stays high as long as the
//   output register is empty or being taken.
//   When the receiver stalls, the whole pipeline holds and req.ready drops;
//   nothing is lost or repeated.
//   Synchronous reset empties the pipeline and restores register defaults.
// ----------------------------------------------------------------------------
module pixel_to_hex_cube_round (
   input  logic                   clock,
   input  logic                   reset,
   p2h_req_if.sink                req,
   p2h_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  p2h_pkg::csr_idx_type   csr_index,
   input  p2h_pkg::csr_data_type  csr_wdata
);
   import p2h_pkg::*;

   coef_type  coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_b3_ff;
   pixel_type origin_x_ff, origin_y_ff;
   cell_type  cell_size_ff;
   cell_type  divisor;

   logic [LAT-1:0] vld_ff;
   logic           adv;

   off_type  off_x, off_y;
   rel_type  rel_x, rel_y;

   prod_type p0_ff, p1_ff, p2_ff, p3_ff;
   sum_type  sum_x, sum_y;
   fix_type  fx_ff, fy_ff;
   fz_type   fz_ff;
   int_type  rx_ff, ry_ff, rz_ff;
   int_type  rx2_ff, ry2_ff;
   err_type  ex_ff, ey_ff, ez_ff;
   err_type  ex2_ff, ey2_ff;
   logic     sel_x, sel_y;
   alt_type  q_in, r_in, s_in;
   alt_type  q_ff, r_ff, s_ff;
   cube_type cube_q_ff, cube_r_ff, cube_s_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff   <= COEF_B0_RST;
         coef_b1_ff   <= COEF_B1_RST;
         coef_b2_ff   <= COEF_B2_RST;
         coef_b3_ff   <= COEF_B3_RST;
         origin_x_ff  <= ORIGIN_RST;
         origin_y_ff  <= ORIGIN_RST;
         cell_size_ff <= CELL_SIZE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COEF_B0:   coef_b0_ff   <= COEF_W'(csr_wdata);
            CSR_COEF_B1:   coef_b1_ff   <= COEF_W'(csr_wdata);
            CSR_COEF_B2:   coef_b2_ff   <= COEF_W'(csr_wdata);
            CSR_COEF_B3:   coef_b3_ff   <= COEF_W'(csr_wdata);
            CSR_ORIGIN_X:  origin_x_ff  <= csr_wdata[PIX_W-1:0];
            CSR_ORIGIN_Y:  origin_y_ff  <= csr_wdata[PIX_W-1:0];
            CSR_CELL_SIZE: cell_size_ff <= csr_wdata[CELL_W-1:0];
            default: ;
         endcase
      end
   end

   assign divisor = (cell_size_ff == '0) ? CELL_W'(1) : cell_size_ff;

   // single stall point at the output register
   assign adv       = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   assign off_x = OFF_W'(req.pixel_x) - OFF_W'(origin_x_ff);
   assign off_y = OFF_W'(req.pixel_y) - OFF_W'(origin_y_ff);

   p2h_div u_div_x (
      .clock   (clock),
      .advance (adv),
      .divisor (divisor),
      .offset  (off_x),
      .rel     (rel_x)
   );

   p2h_div u_div_y (
      .clock   (clock),
      .advance (adv),
      .divisor (divisor),
      .offset  (off_y),
      .rel     (rel_y)
   );

   assign sum_x = SUM_W'(p0_ff) + SUM_W'(p1_ff);
   assign sum_y = SUM_W'(p2_ff) + SUM_W'(p3_ff);

   // strict compares: r wins over q on a tie, s is the fallback
   assign sel_x = (ex2_ff > ey2_ff) && (ex2_ff > ez_ff);
   assign sel_y = !sel_x && (ey2_ff > ez_ff);

   assign q_in = sel_x ? -alt_type'(ry2_ff) - alt_type'(rz_ff) : alt_type'(rx2_ff);
   assign r_in = sel_y ? -alt_type'(rx2_ff) - alt_type'(rz_ff) : alt_type'(ry2_ff);
   assign s_in = (!sel_x && !sel_y) ? -alt_type'(rx2_ff) - alt_type'(ry2_ff)
                                    : alt_type'(rz_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         // matrix products
         p0_ff <= coef_b0_ff * rel_x;
         p1_ff <= coef_b1_ff * rel_y;
         p2_ff <= coef_b2_ff * rel_x;
         p3_ff <= coef_b3_ff * rel_y;
         // floor shift of the sums
         fx_ff <= FIX_W'(sum_x >>> FRAC_BITS);
         fy_ff <= FIX_W'(sum_y >>> FRAC_BITS);
         // third coordinate, round the first two
         fz_ff <= -fz_type'(fx_ff) - fz_type'(fy_ff);
         rx_ff <= round_int(fz_type'(fx_ff));
         ry_ff <= round_int(fz_type'(fy_ff));
         ex_ff <= round_err(fx_ff[FRAC_BITS-1:0]);
         ey_ff <= round_err(fy_ff[FRAC_BITS-1:0]);
         // round the third
         rz_ff  <= round_int(fz_ff);
         ez_ff  <= round_err(fz_ff[FRAC_BITS-1:0]);
         rx2_ff <= rx_ff;
         ry2_ff <= ry_ff;
         ex2_ff <= ex_ff;
         ey2_ff <= ey_ff;
         // recompute the worst one
         q_ff <= q_in;
         r_ff <= r_in;
         s_ff <= s_in;
         // saturate into the output register
         cube_q_ff <= sat_cube(q_ff);
         cube_r_ff <= sat_cube(r_ff);
         cube_s_ff <= sat_cube(s_ff);
      end
   end

   assign rsp.valid  = vld_ff[LAT-1];
   assign rsp.cube_q = cube_q_ff;
   assign rsp.cube_r = cube_r_ff;
   assign rsp.cube_s = cube_s_ff;

endmodule

>>> rtl/p2h_checker.sv
// ----------------------------------------------------------------------------
// p2h_checker
// Port level checks for pixel_to_hex_cube_round, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_to_hex_cube_round_defines.svh"

module p2h_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input p2h_pkg::cube_type  cube_q,
   input p2h_pkg::cube_type  cube_r,
   input p2h_pkg::cube_type  cube_s
);
   import p2h_pkg::*;

   logic signed [CUBE_W+1:0] cube_sum;
   logic                     unclamped;

   assign cube_sum  = (CUBE_W+2)'(cube_q) + (CUBE_W+2)'(cube_r) + (CUBE_W+2)'(cube_s);
   // no coordinate sits on a saturation limit
   assign unclamped = cube_q != CUBE_MIN && cube_q != CUBE_MAX &&
                      cube_r != CUBE_MIN && cube_r != CUBE_MAX &&
                      cube_s != CUBE_MIN && cube_s != CUBE_MAX;

   `P2H_ASSERT_ALWAYS(a_reset_empties, clock, reset |=> !rsp_valid, "response valid after reset")

   `P2H_ASSERT(a_ready_rule, clock, reset, req_ready == (!rsp_valid || rsp_ready), "ready mismatch")

   `P2H_ASSERT(a_cube_sum, clock, reset, (rsp_valid && unclamped) |-> cube_sum == '0, "q + r + s is not zero")

   `P2H_ASSERT(a_stall_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cube_q) && $stable(cube_r) && $stable(cube_s)), "stalled response changed")

endmodule

bind pixel_to_hex_cube_round p2h_checker u_p2h_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .cube_q    (rsp.cube_q),
   .cube_r    (rsp.cube_r),
   .cube_s    (rsp.cube_s)
);

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pixel_to_hex_cube_round. Screen points go in over
// the req channel and are mapped to hexagon cells by a fixed point model of
// the block. Every rsp transfer is compared with the oldest predicted cell.
// Runs directed corner points, then random grid settings and points, with
// random gaps on the sender, stalls on the receiver and one long hold-off.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import p2h_pkg::*;

   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          HOLD_CYCLES    = 200;
   localparam int          RAND_PHASES    = 8;
   localparam int          PHASE_POINTS   = 119;
   localparam csr_idx_type CSR_NO_REG     = '1;

   typedef struct packed {
      cube_type q;
      cube_type r;
      cube_type s;
   } cube_cell_type;

   // predicted cells in transfer order, plus a copy of the grid registers
   class cell_tracker_type;
      longint        m00, m01, m10, m11;
      longint        org_x, org_y;
      longint        size_reg;
      cube_cell_type expected_cells[$];
      int            mismatches;
      int            checked;

      function new();
         m00        = COEF_B0_RST;
         m01        = COEF_B1_RST;
         m10        = COEF_B2_RST;
         m11        = COEF_B3_RST;
         org_x      = ORIGIN_RST;
         org_y      = ORIGIN_RST;
         size_reg   = CELL_SIZE_RST;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void track_write(csr_idx_type idx, csr_data_type data);
         case (idx)
            CSR_COEF_B0:   m00 = $signed(data);
            CSR_COEF_B1:   m01 = $signed(data);
            CSR_COEF_B2:   m10 = $signed(data);
            CSR_COEF_B3:   m11 = $signed(data);
            CSR_ORIGIN_X:  org_x = $signed(data[PIX_W-1:0]);
            CSR_ORIGIN_Y:  org_y = $signed(data[PIX_W-1:0]);
            CSR_CELL_SIZE: size_reg = data[CELL_W-1:0];
            default: ;
         endcase
      endfunction

      // nearest integer, ties away from zero
      function longint nearest(longint v);
         longint half;
         half = longint'(1) << (FRAC_BITS - 1);
         if (v >= 0) begin
            return (v + half) >>> FRAC_BITS;
         end
         return -((-v + half) >>> FRAC_BITS);
      endfunction

      function longint miss(longint r, longint v);
         longint d;
         d = (r <<< FRAC_BITS) - v;
         return (d < 0) ? -d : d;
      endfunction

      function cube_type clamp_cube(longint v);
         if (v < CUBE_MIN) begin
            return CUBE_MIN;
         end
         if (v > CUBE_MAX) begin
            return CUBE_MAX;
         end
         return cube_type'(v);
      endfunction

      function cube_cell_type locate_cell(pixel_type px, pixel_type py);
         longint        one, divisor, relx, rely;
         longint        fx, fy, fz, rx, ry, rz, ex, ey, ez;
         cube_cell_type c;
         one     = longint'(1) << FRAC_BITS;
         divisor = (size_reg == 0) ? 1 : size_reg;
         // division truncates toward zero, the shift below floors
         relx = ((longint'(px) - org_x) * one) / divisor;
         rely = ((longint'(py) - org_y) * one) / divisor;
         fx   = (m00 * relx + m01 * rely) >>> FRAC_BITS;
         fy   = (m10 * relx + m11 * rely) >>> FRAC_BITS;
         fz   = -fx - fy;
         rx   = nearest(fx);
         ry   = nearest(fy);
         rz   = nearest(fz);
         ex   = miss(rx, fx);
         ey   = miss(ry, fy);
         ez   = miss(rz, fz);
         // strict compares: r wins ties over q, s is the fallback
         if (ex > ey && ex > ez) begin
            rx = -ry - rz;
         end else if (ey > ez) begin
            ry = -rx - rz;
         end else begin
            rz = -rx - ry;
         end
         c.q = clamp_cube(rx);
         c.r = clamp_cube(ry);
         c.s = clamp_cube(rz);
         return c;
      endfunction

      function void note(pixel_type px, pixel_type py);
         expected_cells.insert(expected_cells.size(), locate_cell(px, py));
      endfunction

      function int pending();
         return expected_cells.size();
      endfunction

      function void report(string what, cube_cell_type want, cube_cell_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: %s: expected q=%0d r=%0d s=%0d, got q=%0d r=%0d s=%0d",
                     what, $signed(want.q), $signed(want.r), $signed(want.s),
                     $signed(got.q), $signed(got.r), $signed(got.s));
         end
      endfunction

      function void check(cube_type q, cube_type r, cube_type s);
         cube_cell_type got;
         cube_cell_type want;
         got.q = q;
         got.r = r;
         got.s = s;
         if (expected_cells.size() == 0) begin
            report("cell with no pixel pending", '0, got);
         end else begin
            want = expected_cells.pop_front();
            checked++;
            if (got.q !== want.q || got.r !== want.r || got.s !== want.s) begin
               report("wrong cell", want, got);
            end
         end
      endfunction

      function void close_out();
         if (expected_cells.size() != 0) begin
            mismatches += expected_cells.size();
            $display("mismatch: %0d expected cells never arrived", expected_cells.size());
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset;
   logic         csr_we;
   csr_idx_type  csr_index;
   csr_data_type csr_wdata;

   p2h_req_if req ();
   p2h_rsp_if rsp ();

   pixel_to_hex_cube_round dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   cell_tracker_type cells = new();

   int        gap_pct   = 0;
   int        stall_pct = 0;
   int        hold_asks = 0;
   int        cells_in  = 0;
   int        settings  = 1;
   int        quiet     = 0;
   pixel_type grid_ox   = ORIGIN_RST;
   pixel_type grid_oy   = ORIGIN_RST;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: random stalls, plus a long hold-off when one is asked for
   initial begin
      int hold_seen;
      int hold_left;
      hold_seen = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready) begin
            cells.note(req.pixel_x, req.pixel_y);
            cells_in++;
         end
         if (rsp.valid && rsp.ready) begin
            cells.check(rsp.cube_q, rsp.cube_r, rsp.cube_s);
         end
      end
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || csr_we) begin
         quiet = 0;
      end else begin
         quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic offer_pixel(pixel_type px, pixel_type py);
      while ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.pixel_x <= px;
      req.pixel_y <= py;
      do @(posedge clock); while (!req.ready);
   endtask

   // drop valid and wait until every predicted cell has come back
   task automatic settle();
      req.valid <= 1'b0;
      do @(posedge clock); while (cells.pending() != 0);
   endtask

   task automatic write_csr(csr_idx_type idx, csr_data_type data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      cells.track_write(idx, data);
      @(posedge clock);
   endtask

   task automatic program_grid(csr_data_type b0, csr_data_type b1, csr_data_type b2,
                               csr_data_type b3, pixel_type ox, pixel_type oy,
                               csr_data_type size);
      write_csr(CSR_COEF_B0, b0);
      write_csr(CSR_COEF_B1, b1);
      write_csr(CSR_COEF_B2, b2);
      write_csr(CSR_COEF_B3, b3);
      write_csr(CSR_ORIGIN_X, csr_data_type'(ox));
      write_csr(CSR_ORIGIN_Y, csr_data_type'(oy));
      write_csr(CSR_CELL_SIZE, size);
      // a write to an unused index must change nothing
      write_csr(CSR_NO_REG, csr_data_type'($urandom));
      csr_we  <= 1'b0;
      grid_ox  = ox;
      grid_oy  = oy;
      settings++;
   endtask

   // mostly near the origin so cells stay in range, else anywhere
   function automatic pixel_type pick_pixel(pixel_type org);
      if ($urandom_range(2) == 0) begin
         return pixel_type'($urandom);
      end
      return pixel_type'(int'(org) + int'($urandom_range(4000)) - 2000);
   endfunction

   initial begin
      int           base [4];
      csr_data_type mat [4];
      csr_data_type size;
      reset       = 1'b1;
      req.valid   = 1'b0;
      req.pixel_x = '0;
      req.pixel_y = '0;
      csr_we      = 1'b0;
      csr_index   = CSR_COEF_B0;
      csr_wdata   = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // register defaults: field extremes and a few ordinary points
      offer_pixel(16'sd0, 16'sd0);
      offer_pixel(16'sd32767, 16'sd32767);
      offer_pixel(-16'sd32768, -16'sd32768);
      offer_pixel(16'sd32767, -16'sd32768);
      offer_pixel(-16'sd32768, 16'sd32767);
      offer_pixel(16'sd7, 16'sd3);
      offer_pixel(-16'sd7, -16'sd3);
      settle();

      // identity matrix at cell size 2: exact halves, error ties, saturation
      program_grid(18'd65536, 18'd0, 18'd0, 18'd65536, 16'sd0, 16'sd0, 18'd2);
      offer_pixel(16'sd1, 16'sd1);
      offer_pixel(-16'sd1, -16'sd1);
      offer_pixel(16'sd1, 16'sd0);
      offer_pixel(16'sd1, -16'sd1);
      offer_pixel(16'sd32767, 16'sd32767);
      settle();

      // coefficient and origin extremes, zero cell size divides by one
      program_grid(18'h1FFFF, 18'h20000, 18'h20000, 18'h1FFFF,
                   16'sd32767, -16'sd32768, 18'd0);
      offer_pixel(-16'sd32768, 16'sd32767);
      offer_pixel(16'sd32767, -16'sd32768);
      offer_pixel(16'sd0, 16'sd0);
      offer_pixel(-16'sd1, 16'sd1);
      settle();

      // large cell size of 1000, opposite origin corner
      program_grid(18'd43691, 18'd0, -18'sd21845, 18'd37837,
                   -16'sd32768, 16'sd32767, 18'd1000);
      offer_pixel(16'sd32767, -16'sd32768);
      offer_pixel(-16'sd32768, 16'sd32767);
      offer_pixel(16'sd0, 16'sd0);
      settle();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         case ($urandom_range(3))
            0: begin
               base = '{37837, -21845, 0, 43691};
               foreach (mat[i]) mat[i] = csr_data_type'(base[i]);
            end
            1: begin
               base = '{43691, 0, -21845, 37837};
               foreach (mat[i]) mat[i] = csr_data_type'(base[i]);
            end
            2: begin
               base = '{37837, -21845, 0, 43691};
               foreach (mat[i]) begin
                  mat[i] = csr_data_type'(base[i] + int'($urandom_range(4000)) - 2000);
               end
            end
            default: begin
               foreach (mat[i]) mat[i] = csr_data_type'($urandom);
            end
         endcase
         case ($urandom_range(9))
            0:       size = csr_data_type'($urandom_range(9));
            1:       size = csr_data_type'($urandom_range(1023, 1001));
            2, 3, 4: size = csr_data_type'($urandom_range(1000, 10));
            default: size = csr_data_type'($urandom_range(60, 10));
         endcase
         case (ph % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 56; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 56; end
            default: begin gap_pct = 36; stall_pct = 36; end
         endcase
         program_grid(mat[0], mat[1], mat[2], mat[3], pixel_type'($urandom),
                      pixel_type'($urandom), size);
         // receiver stops for a long stretch while points keep coming
         if (ph == 2) begin
            hold_asks++;
         end
         repeat (PHASE_POINTS) offer_pixel(pick_pixel(grid_ox), pick_pixel(grid_oy));
         settle();
      end

      repeat (2 * LAT) @(posedge clock);
      cells.close_out();
      $display("tb: %0d pixels mapped under %0d grid settings, %0d cells compared",
               cells_in, settings, cells.checked);
      $display("tb: covered field extremes, zero and oversized cells, error ties, clamping");
      if (cells.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
